// File: rtl/spg_pkg.sv
// Package: shared constants, codes and types of the sink particle gravity block
`default_nettype none
package spg_pkg;
	localparam int NUM_SINKS_DEF = 8;

	localparam int CMD_W    = 2;
	localparam int IDX_IN_W = 3;
	localparam int POS_W    = 32;
	localparam int MASS_W   = 32;
	localparam int ACC_W    = 48;
	localparam int ACT_W    = 4;
	localparam int CFG_AW   = 4;
	localparam int CFG_DW   = 32;

	localparam logic [CFG_DW-1:0] GRAV_RST  = 32'd65536;
	localparam logic [CFG_DW-1:0] PMASS_RST = 32'd65536;
	localparam logic [ACT_W-1:0]  ACT_RST   = 4'd0;

	localparam int DIST_W = POS_W + 1;
	localparam int SQ_W   = 2 * DIST_W;
	localparam int ROOT_W = 34;
	localparam int DEN_W  = SQ_W + ROOT_W;
	localparam int GM_W   = 2 * MASS_W;
	localparam int NUM_W  = GM_W + DIST_W;
	localparam int MAG_W  = ACC_W;
	localparam int LANES  = 6;

	localparam int HALF_W = 34;
	localparam int MUL_W  = 2 * HALF_W;
	localparam int PROD_W = 2 * MUL_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD = 2'd0,
		CMD_PART = 2'd1,
		CMD_READ = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_GRAV   = 2'd0,
		REG_PMASS  = 2'd1,
		REG_ACTIVE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_DW-1:0] grav;
		logic [CFG_DW-1:0] pmass;
		logic [ACT_W-1:0]  active;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0]  px;
		logic [POS_W-1:0]  py;
		logic [POS_W-1:0]  pz;
		logic [MASS_W-1:0] w;
		logic [MASS_W-1:0] r;
	} sink_t;

	typedef logic [2:0][ACC_W-1:0]       acc3_t;
	typedef logic [LANES-1:0][NUM_W-1:0] num_arr_t;
	typedef logic [LANES-1:0][MAG_W-1:0] mag_arr_t;
endpackage
`default_nettype wire

// File: rtl/spg_in_if.sv
// Interface: input item channel
`default_nettype none
interface spg_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [spg_pkg::CMD_W-1:0]             command;
	logic [spg_pkg::IDX_IN_W-1:0]          sink_index;
	logic signed [spg_pkg::POS_W-1:0]      pos_x;
	logic signed [spg_pkg::POS_W-1:0]      pos_y;
	logic signed [spg_pkg::POS_W-1:0]      pos_z;
	logic [spg_pkg::MASS_W-1:0]            body_mass;
	logic [spg_pkg::MASS_W-1:0]            capture_radius;

	modport source (output valid, command, sink_index, pos_x, pos_y, pos_z, body_mass,
		capture_radius, input ready);
	modport sink (input valid, command, sink_index, pos_x, pos_y, pos_z, body_mass,
		capture_radius, output ready);
endinterface
`default_nettype wire

// File: rtl/spg_out_if.sv
// Interface: result item channel
`default_nettype none
interface spg_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [spg_pkg::ACC_W-1:0] acc_x;
	logic signed [spg_pkg::ACC_W-1:0] acc_y;
	logic signed [spg_pkg::ACC_W-1:0] acc_z;

	modport source (output valid, acc_x, acc_y, acc_z, input ready);
	modport sink (input valid, acc_x, acc_y, acc_z, output ready);
endinterface
`default_nettype wire

// File: rtl/sink_particle_gravity.sv
// Top level: sink table memories, per-sink sequencer and arithmetic units
//
//  channel   dir  handshake      payload
//  items     in   valid/ready    command, sink_index, pos_x/y/z, body_mass, capture_radius
//  results   out  valid/ready    acc_x, acc_y, acc_z
//  apb       in   psel/penable   gravity_constant, particle_mass, active_sinks
//
// Load writes the sink table directly; a read goes through the table read register to the
// result register. A particle visits each active sink: 13 passes through the 4-product
// multiplier, 34 sqrt steps and 49 shared divider steps when it pulls, fewer when it does not.
// One transaction is in work at a time; the result register frees the input side while
// a result waits. No clearing pass after reset: accumulator entries carry valid flops.
`default_nettype none
module sink_particle_gravity #(
	parameter int NUM_SINKS = spg_pkg::NUM_SINKS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	spg_in_if.sink                           items,
	spg_out_if.source                        results,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [spg_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [spg_pkg::CFG_DW-1:0]  pwdata,
	output logic      [spg_pkg::CFG_DW-1:0]  prdata,
	output logic                             pready
);
	localparam int IDX_W = (NUM_SINKS > 1) ? $clog2(NUM_SINKS) : 1;
	localparam int CNT_W = $clog2(NUM_SINKS + 1);
	localparam int AW    = spg_pkg::ACC_W;
	localparam logic [AW-1:0] ACC_MAX = {1'b0, {(AW - 1){1'b1}}};
	localparam logic [AW-1:0] ACC_MIN = {1'b1, {(AW - 1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE, ST_RDACC, ST_ISSUE, ST_DELTA, ST_MUL, ST_MULW, ST_CHECK,
		ST_SQRTW, ST_DIVS, ST_DIVW, ST_UPD, ST_NEXT, ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		MOP_SQX, MOP_SQY, MOP_SQZ, MOP_RAD, MOP_GMS, MOP_GMP, MOP_DEN,
		MOP_PX, MOP_PY, MOP_PZ, MOP_SX, MOP_SY, MOP_SZ
	} mop_t;

	function automatic logic [AW-1:0] apply_sign(input logic [AW-1:0] m, input logic neg);
		logic [AW-1:0] r;
		if (neg)
			r = AW'(0) - m;
		else
			r = m[AW-1] ? ACC_MAX : m;
		return r;
	endfunction

	function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0]   s;
		logic [AW-1:0] r;
		s = {a[AW-1], a} + {b[AW-1], b};
		if (s[AW] != s[AW-1])
			r = s[AW] ? ACC_MIN : ACC_MAX;
		else
			r = s[AW-1:0];
		return r;
	endfunction

	spg_pkg::cfg_t cfg;

	state_t            state_q;
	mop_t              mop_q;
	logic [CNT_W-1:0]  s_q, n_q, n_in;
	logic              res_vld_q;
	spg_pkg::acc3_t    res_q;

	spg_pkg::sink_t    prm_mem [NUM_SINKS];
	spg_pkg::acc3_t    acc_mem [NUM_SINKS];
	logic [NUM_SINKS-1:0] acc_vld_q;
	spg_pkg::sink_t    prm_rd_q, prm_wd;
	spg_pkg::acc3_t    acc_rd_q, acc_wd;
	logic              vld_rd_q;
	logic              rd_en, prm_we, acc_we;
	logic [IDX_W-1:0]  rd_addr, wr_addr;

	logic              accept, idx_ok_in, skip;
	spg_pkg::cmd_t     cmd_in;

	logic [2:0][spg_pkg::POS_W-1:0]  pos_q, sp;
	logic [2:0][spg_pkg::DIST_W-1:0] mag_q;
	logic [2:0]                      neg_q;
	spg_pkg::acc3_t                  sacc_q, sum_q, acc_new, sum_new;
	logic [spg_pkg::SQ_W-1:0]        sq_q;
	logic [2*spg_pkg::MASS_W-1:0]    r2_q;
	logic [spg_pkg::GM_W-1:0]        gms_q, gmp_q;
	logic [spg_pkg::ROOT_W-1:0]      root_q;
	logic [spg_pkg::DEN_W-1:0]       den_q;
	spg_pkg::num_arr_t               num_q;

	logic                        mul_start, mul_done;
	logic [spg_pkg::MUL_W-1:0]   mul_a, mul_b;
	logic [spg_pkg::PROD_W-1:0]  mul_p;
	logic                        sqrt_start, sqrt_done;
	logic [spg_pkg::ROOT_W-1:0]  sqrt_root;
	logic                        div_start, div_done;
	spg_pkg::mag_arr_t           div_mag;

	spg_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	spg_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p)
	);

	spg_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .radicand(sq_q),
		.done(sqrt_done), .root(sqrt_root)
	);

	spg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .den(den_q), .num(num_q),
		.done(div_done), .mag(div_mag)
	);

	assign items.ready   = (state_q == ST_IDLE);
	assign accept        = items.valid && items.ready;
	assign cmd_in        = spg_pkg::cmd_t'(items.command);
	assign idx_ok_in     = 32'(items.sink_index) < NUM_SINKS;
	assign n_in          = (32'(cfg.active) > NUM_SINKS) ? CNT_W'(NUM_SINKS) : CNT_W'(cfg.active);
	assign skip          = (sq_q == '0) || (sq_q < spg_pkg::SQ_W'(r2_q));
	assign mul_start     = (state_q == ST_MUL);
	assign sqrt_start    = (state_q == ST_CHECK) && !skip;
	assign div_start     = (state_q == ST_DIVS);

	assign results.valid = res_vld_q;
	assign results.acc_x = res_q[0];
	assign results.acc_y = res_q[1];
	assign results.acc_z = res_q[2];

	assign prm_wd.px = items.pos_x;
	assign prm_wd.py = items.pos_y;
	assign prm_wd.pz = items.pos_z;
	assign prm_wd.w  = items.body_mass;
	assign prm_wd.r  = items.capture_radius;

	assign sp[0] = prm_rd_q.px;
	assign sp[1] = prm_rd_q.py;
	assign sp[2] = prm_rd_q.pz;

	always_comb begin
		rd_en   = 1'b0;
		prm_we  = 1'b0;
		acc_we  = 1'b0;
		rd_addr = s_q[IDX_W-1:0];
		wr_addr = s_q[IDX_W-1:0];
		acc_wd  = '0;
		case (state_q)
			ST_IDLE: begin
				rd_addr = IDX_W'(items.sink_index);
				wr_addr = IDX_W'(items.sink_index);
				if (accept && idx_ok_in) begin
					if (cmd_in == spg_pkg::CMD_LOAD) begin
						prm_we = 1'b1;
						acc_we = 1'b1;
					end else if (cmd_in == spg_pkg::CMD_READ) begin
						rd_en = 1'b1;
					end
				end
			end
			ST_ISSUE: rd_en = 1'b1;
			ST_UPD: begin
				acc_we = 1'b1;
				acc_wd = acc_new;
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc_new[c] = sat_add(sacc_q[c], apply_sign(div_mag[c + 3], neg_q[c]));
			sum_new[c] = sat_add(sum_q[c], apply_sign(div_mag[c], !neg_q[c]));
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (mop_q)
			MOP_SQX: begin mul_a = spg_pkg::MUL_W'(mag_q[0]); mul_b = spg_pkg::MUL_W'(mag_q[0]); end
			MOP_SQY: begin mul_a = spg_pkg::MUL_W'(mag_q[1]); mul_b = spg_pkg::MUL_W'(mag_q[1]); end
			MOP_SQZ: begin mul_a = spg_pkg::MUL_W'(mag_q[2]); mul_b = spg_pkg::MUL_W'(mag_q[2]); end
			MOP_RAD: begin mul_a = spg_pkg::MUL_W'(prm_rd_q.r); mul_b = spg_pkg::MUL_W'(prm_rd_q.r); end
			MOP_GMS: begin mul_a = spg_pkg::MUL_W'(cfg.grav); mul_b = spg_pkg::MUL_W'(prm_rd_q.w); end
			MOP_GMP: begin mul_a = spg_pkg::MUL_W'(cfg.grav); mul_b = spg_pkg::MUL_W'(cfg.pmass); end
			MOP_DEN: begin mul_a = spg_pkg::MUL_W'(sq_q); mul_b = spg_pkg::MUL_W'(root_q); end
			MOP_PX:  begin mul_a = spg_pkg::MUL_W'(gms_q); mul_b = spg_pkg::MUL_W'(mag_q[0]); end
			MOP_PY:  begin mul_a = spg_pkg::MUL_W'(gms_q); mul_b = spg_pkg::MUL_W'(mag_q[1]); end
			MOP_PZ:  begin mul_a = spg_pkg::MUL_W'(gms_q); mul_b = spg_pkg::MUL_W'(mag_q[2]); end
			MOP_SX:  begin mul_a = spg_pkg::MUL_W'(gmp_q); mul_b = spg_pkg::MUL_W'(mag_q[0]); end
			MOP_SY:  begin mul_a = spg_pkg::MUL_W'(gmp_q); mul_b = spg_pkg::MUL_W'(mag_q[1]); end
			MOP_SZ:  begin mul_a = spg_pkg::MUL_W'(gmp_q); mul_b = spg_pkg::MUL_W'(mag_q[2]); end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (prm_we)
			prm_mem[wr_addr] <= prm_wd;
		if (acc_we)
			acc_mem[wr_addr] <= acc_wd;
		if (rd_en) begin
			prm_rd_q <= prm_mem[rd_addr];
			acc_rd_q <= acc_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
			vld_rd_q  <= 1'b0;
		end else begin
			if (acc_we)
				acc_vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				vld_rd_q <= acc_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mop_q     <= MOP_SQX;
			s_q       <= '0;
			n_q       <= '0;
			res_vld_q <= 1'b0;
			res_q     <= '0;
		end else begin
			if (res_vld_q && results.ready && (state_q != ST_DONE))
				res_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd_in)
							spg_pkg::CMD_READ: state_q <= idx_ok_in ? ST_RDACC : ST_DONE;
							spg_pkg::CMD_PART: begin
								n_q     <= n_in;
								s_q     <= '0;
								state_q <= (n_in == '0) ? ST_DONE : ST_ISSUE;
							end
							default: ;
						endcase
					end
				end
				ST_RDACC: state_q <= ST_DONE;
				ST_ISSUE: state_q <= ST_DELTA;
				ST_DELTA: begin
					mop_q   <= MOP_SQX;
					state_q <= ST_MUL;
				end
				ST_MUL:   state_q <= ST_MULW;
				ST_MULW: begin
					if (mul_done) begin
						case (mop_q)
							MOP_GMP: state_q <= ST_CHECK;
							MOP_SZ:  state_q <= ST_DIVS;
							default: begin
								mop_q   <= mop_t'(mop_q + 4'd1);
								state_q <= ST_MUL;
							end
						endcase
					end
				end
				ST_CHECK: state_q <= skip ? ST_NEXT : ST_SQRTW;
				ST_SQRTW: begin
					if (sqrt_done) begin
						mop_q   <= MOP_DEN;
						state_q <= ST_MUL;
					end
				end
				ST_DIVS:  state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_done)
						state_q <= ST_UPD;
				end
				ST_UPD:   state_q <= ST_NEXT;
				ST_NEXT: begin
					if (s_q + CNT_W'(1) == n_q) begin
						state_q <= ST_DONE;
					end else begin
						s_q     <= s_q + CNT_W'(1);
						state_q <= ST_ISSUE;
					end
				end
				ST_DONE: begin
					if (!res_vld_q || results.ready) begin
						res_vld_q <= 1'b1;
						res_q     <= sum_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sum_q    <= '0;
				pos_q[0] <= items.pos_x;
				pos_q[1] <= items.pos_y;
				pos_q[2] <= items.pos_z;
			end
			ST_RDACC: sum_q <= vld_rd_q ? acc_rd_q : '0;
			ST_DELTA: begin
				sacc_q <= vld_rd_q ? acc_rd_q : '0;
				for (int c = 0; c < 3; c++) begin
					logic [spg_pkg::DIST_W-1:0] d;
					d = {pos_q[c][spg_pkg::POS_W-1], pos_q[c]} - {sp[c][spg_pkg::POS_W-1], sp[c]};
					neg_q[c] <= d[spg_pkg::DIST_W-1];
					mag_q[c] <= d[spg_pkg::DIST_W-1] ? (spg_pkg::DIST_W'(0) - d) : d;
				end
			end
			ST_MULW: begin
				if (mul_done) begin
					case (mop_q)
						MOP_SQX: sq_q <= mul_p[spg_pkg::SQ_W-1:0];
						MOP_SQY, MOP_SQZ: sq_q <= sq_q + mul_p[spg_pkg::SQ_W-1:0];
						MOP_RAD: r2_q <= mul_p[2*spg_pkg::MASS_W-1:0];
						MOP_GMS: gms_q <= mul_p[spg_pkg::GM_W-1:0];
						MOP_GMP: gmp_q <= mul_p[spg_pkg::GM_W-1:0];
						MOP_DEN: den_q <= mul_p[spg_pkg::DEN_W-1:0];
						MOP_PX:  num_q[0] <= mul_p[spg_pkg::NUM_W-1:0];
						MOP_PY:  num_q[1] <= mul_p[spg_pkg::NUM_W-1:0];
						MOP_PZ:  num_q[2] <= mul_p[spg_pkg::NUM_W-1:0];
						MOP_SX:  num_q[3] <= mul_p[spg_pkg::NUM_W-1:0];
						MOP_SY:  num_q[4] <= mul_p[spg_pkg::NUM_W-1:0];
						MOP_SZ:  num_q[5] <= mul_p[spg_pkg::NUM_W-1:0];
						default: ;
					endcase
				end
			end
			ST_SQRTW: begin
				if (sqrt_done)
					root_q <= sqrt_root;
			end
			ST_UPD: sum_q <= sum_new;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/spg_cfg.sv
// Configuration registers behind the APB-style port
`default_nettype none
module spg_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [spg_pkg::CFG_AW-1:0]   paddr,
	input  wire logic [spg_pkg::CFG_DW-1:0]   pwdata,
	output logic      [spg_pkg::CFG_DW-1:0]   prdata,
	output logic                              pready,
	output spg_pkg::cfg_t                     cfg
);
	spg_pkg::reg_idx_t sel;
	spg_pkg::cfg_t     cfg_q;

	assign sel    = spg_pkg::reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grav   <= spg_pkg::GRAV_RST;
			cfg_q.pmass  <= spg_pkg::PMASS_RST;
			cfg_q.active <= spg_pkg::ACT_RST;
		end else if (psel && penable && pwrite) begin
			case (sel)
				spg_pkg::REG_GRAV:   cfg_q.grav   <= pwdata;
				spg_pkg::REG_PMASS:  cfg_q.pmass  <= pwdata;
				spg_pkg::REG_ACTIVE: cfg_q.active <= pwdata[spg_pkg::ACT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			spg_pkg::REG_GRAV:   prdata = cfg_q.grav;
			spg_pkg::REG_PMASS:  prdata = cfg_q.pmass;
			spg_pkg::REG_ACTIVE: prdata = spg_pkg::CFG_DW'(cfg_q.active);
			default:             prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/spg_mul.sv
// Multicycle unsigned multiplier, four 34x34 partial products
`default_nettype none
module spg_mul (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [spg_pkg::MUL_W-1:0]   a,
	input  wire logic [spg_pkg::MUL_W-1:0]   b,
	output logic                             done,
	output logic [spg_pkg::PROD_W-1:0]       p
);
	localparam int HW = spg_pkg::HALF_W;

	logic [spg_pkg::MUL_W-1:0]  a_q, b_q;
	logic [1:0]                 cnt_q;
	logic                       busy_q, done_q;
	logic [HW-1:0]              a_ch, b_ch;
	logic [2*HW-1:0]            pp_s1;
	logic [1:0]                 sh_s1;
	logic                       pv_s1, last_s1;
	logic [spg_pkg::PROD_W-1:0] acc_q;

	assign a_ch = cnt_q[1] ? a_q[2*HW-1:HW] : a_q[HW-1:0];
	assign b_ch = cnt_q[0] ? b_q[2*HW-1:HW] : b_q[HW-1:0];
	assign done = done_q;
	assign p    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			pv_s1   <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= pv_s1 && last_s1;
			pv_s1   <= busy_q;
			last_s1 <= busy_q && (cnt_q == 2'd3);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (pv_s1) begin
			case (sh_s1)
				2'd0:    acc_q <= acc_q + spg_pkg::PROD_W'(pp_s1);
				2'd1:    acc_q <= acc_q + (spg_pkg::PROD_W'(pp_s1) << HW);
				default: acc_q <= acc_q + (spg_pkg::PROD_W'(pp_s1) << (2 * HW));
			endcase
		end
		pp_s1 <= a_ch * b_ch;
		sh_s1 <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
	end
endmodule
`default_nettype wire

// File: rtl/spg_sqrt.sv
// Iterative integer square root, one result bit per cycle
`default_nettype none
module spg_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [spg_pkg::SQ_W-1:0]    radicand,
	output logic                             done,
	output logic [spg_pkg::ROOT_W-1:0]       root
);
	localparam int OP_W  = spg_pkg::SQ_W + 2;
	localparam int CNT_W = $clog2(spg_pkg::ROOT_W + 1);

	logic [OP_W-1:0]  op_q, res_q, one_q, trial;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;

	assign trial = res_q + one_q;
	assign done  = done_q;
	assign root  = res_q[spg_pkg::ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(spg_pkg::ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= OP_W'(radicand);
			res_q <= '0;
			one_q <= OP_W'(1) << (OP_W - 2);
		end else if (busy_q) begin
			if (op_q >= trial) begin
				op_q  <= op_q - trial;
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end
	end
endmodule
`default_nettype wire

// File: rtl/spg_div.sv
// Six-lane restoring divider over a shared divisor, saturating quotient
`default_nettype none
module spg_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [spg_pkg::DEN_W-1:0]   den,
	input  wire spg_pkg::num_arr_t           num,
	output logic                             done,
	output spg_pkg::mag_arr_t                mag
);
	localparam int QUO_W = spg_pkg::MAG_W + 1;
	localparam int FRAC  = 24;
	localparam int REM_W = spg_pkg::NUM_W + FRAC;
	localparam int DSH_W = spg_pkg::DEN_W + QUO_W - 1;
	localparam int CNT_W = $clog2(QUO_W + 1);
	localparam logic [spg_pkg::MAG_W-1:0] SAT = spg_pkg::MAG_W'(1) << (spg_pkg::MAG_W - 1);

	logic [spg_pkg::LANES-1:0][REM_W-1:0] rem_q;
	logic [spg_pkg::LANES-1:0][QUO_W-1:0] quo_q;
	logic [spg_pkg::LANES-1:0]            ge;
	logic [DSH_W-1:0]                     dsh_q;
	logic [CNT_W-1:0]                     cnt_q;
	logic                                 busy_q, done_q;

	assign done = done_q;

	always_comb begin
		for (int l = 0; l < spg_pkg::LANES; l++) begin
			ge[l] = DSH_W'(rem_q[l]) >= dsh_q;
			if (quo_q[l][QUO_W-1] || (quo_q[l][QUO_W-2] && (|quo_q[l][QUO_W-3:0])))
				mag[l] = SAT;
			else
				mag[l] = quo_q[l][spg_pkg::MAG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dsh_q <= {den, (QUO_W - 1)'(0)};
			for (int l = 0; l < spg_pkg::LANES; l++) begin
				rem_q[l] <= {num[l], FRAC'(0)};
				quo_q[l] <= '0;
			end
		end else if (busy_q) begin
			dsh_q <= dsh_q >> 1;
			for (int l = 0; l < spg_pkg::LANES; l++) begin
				if (ge[l])
					rem_q[l] <= rem_q[l] - dsh_q[REM_W-1:0];
				quo_q[l] <= {quo_q[l][QUO_W-2:0], ge[l]};
			end
		end
	end
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Testbench: random and directed transactions against a bit-exact model of sink particle gravity
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	localparam logic [spg_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint ACC_MIN = -ACC_MAX - 1;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE = 20;
	localparam int PHASE_ITEMS = 205;

	typedef struct {
		logic [spg_pkg::CMD_W-1:0] command;
		logic [2:0]                sink_index;
		logic [31:0]               px, py, pz, mass, radius;
	} item_t;

	typedef struct {
		longint x, y, z;
	} accel_t;

	class gravity_scoreboard;
		logic [31:0] grav, pmass;
		logic [3:0]  active;
		logic [31:0] spx[8], spy[8], spz[8], sw[8], sr[8];
		longint      sax[8], say[8], saz[8];
		accel_t      pending[$];
		int          errors;

		function new();
			grav = spg_pkg::GRAV_RST;
			pmass = spg_pkg::PMASS_RST;
			active = spg_pkg::ACT_RST;
			errors = 0;
			for (int i = 0; i < 8; i++) begin
				spx[i] = 0; spy[i] = 0; spz[i] = 0; sw[i] = 0; sr[i] = 0;
				sax[i] = 0; say[i] = 0; saz[i] = 0;
			end
		endfunction

		function void set_reg(spg_pkg::reg_idx_t idx, logic [31:0] val);
			case (idx)
				spg_pkg::REG_GRAV:   grav = val;
				spg_pkg::REG_PMASS:  pmass = val;
				spg_pkg::REG_ACTIVE: active = val[3:0];
				default: ;
			endcase
		endfunction

		function longint sat_add(longint a, longint b);
			longint s;
			s = a + b;
			if (s > ACC_MAX) return ACC_MAX;
			if (s < ACC_MIN) return ACC_MIN;
			return s;
		endfunction

		function logic [127:0] int_root(logic [127:0] s);
			logic [127:0] res, c;
			res = 0;
			for (int b = 33; b >= 0; b--) begin
				c = res | (128'd1 << b);
				if (c * c <= s) res = c;
			end
			return res;
		endfunction

		// one axis term: floor(gm*|d|*2^24/den), clamped to 2^47, then signed
		function longint axis_pull(logic [63:0] gm, logic [32:0] mag, logic [127:0] den,
				bit neg);
			logic [127:0] num, quo;
			longint m;
			num = ({64'd0, gm} * {95'd0, mag}) << 24;
			quo = num / den;
			m = (quo > (128'd1 << 47)) ? (64'sd1 <<< 47) : longint'(quo[47:0]);
			if (neg) return -m;
			return (m > ACC_MAX) ? ACC_MAX : m;
		endfunction

		function void note_item(item_t it);
			accel_t a;
			int n;
			logic signed [32:0] d[3];
			logic [32:0] mag[3];
			logic [127:0] sq, r2, den;
			logic [63:0] gm_sink, gm_part;
			a = '{0, 0, 0};
			case (it.command)
				spg_pkg::CMD_LOAD: begin
					spx[it.sink_index] = it.px; spy[it.sink_index] = it.py;
					spz[it.sink_index] = it.pz; sw[it.sink_index] = it.mass;
					sr[it.sink_index] = it.radius;
					sax[it.sink_index] = 0; say[it.sink_index] = 0; saz[it.sink_index] = 0;
					return;
				end
				spg_pkg::CMD_READ: begin
					a.x = sax[it.sink_index]; a.y = say[it.sink_index];
					a.z = saz[it.sink_index];
				end
				spg_pkg::CMD_PART: begin
					n = (active > 8) ? 8 : active;
					gm_part = {32'd0, grav} * {32'd0, pmass};
					for (int s = 0; s < n; s++) begin
						d[0] = {it.px[31], it.px} - {spx[s][31], spx[s]};
						d[1] = {it.py[31], it.py} - {spy[s][31], spy[s]};
						d[2] = {it.pz[31], it.pz} - {spz[s][31], spz[s]};
						sq = 0;
						for (int c = 0; c < 3; c++) begin
							mag[c] = d[c][32] ? (~d[c] + 33'd1) : d[c];
							sq = sq + {95'd0, mag[c]} * {95'd0, mag[c]};
						end
						r2 = {96'd0, sr[s]} * {96'd0, sr[s]};
						if (sq == 0 || sq < r2) continue;
						den = sq * int_root(sq);
						gm_sink = {32'd0, grav} * {32'd0, sw[s]};
						a.x = sat_add(a.x, axis_pull(gm_sink, mag[0], den, !d[0][32]));
						a.y = sat_add(a.y, axis_pull(gm_sink, mag[1], den, !d[1][32]));
						a.z = sat_add(a.z, axis_pull(gm_sink, mag[2], den, !d[2][32]));
						sax[s] = sat_add(sax[s], axis_pull(gm_part, mag[0], den, d[0][32]));
						say[s] = sat_add(say[s], axis_pull(gm_part, mag[1], den, d[1][32]));
						saz[s] = sat_add(saz[s], axis_pull(gm_part, mag[2], den, d[2][32]));
					end
				end
				default: return;
			endcase
			pending = {pending, a};
		endfunction

		function void check_result(logic [47:0] x, logic [47:0] y, logic [47:0] z);
			accel_t a;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h %h %h", x, y, z);
				return;
			end
			a = pending.pop_front();
			if (x !== a.x[47:0] || y !== a.y[47:0] || z !== a.z[47:0]) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %h %h %h, got %h %h %h",
						a.x[47:0], a.y[47:0], a.z[47:0], x, y, z);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel, penable, pwrite, pready;
	logic [spg_pkg::CFG_AW-1:0] paddr;
	logic [spg_pkg::CFG_DW-1:0] pwdata, prdata;

	spg_in_if  items_if();
	spg_out_if results_if();

	gravity_scoreboard sb = new();

	int send_idle = 0;
	int recv_idle = 0;
	int hold_cycles = 0;
	int quiet = 0;
	logic [31:0] center;

	sink_particle_gravity i_dut (
		.clk(clk), .arst_n(arst_n), .items(items_if), .results(results_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else begin
			if (results_if.valid && results_if.ready)
				sb.check_result(results_if.acc_x, results_if.acc_y, results_if.acc_z);
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("FAIL sink_particle_gravity");
			$finish;
		end
	end

	task automatic send_item(input item_t it);
		items_if.valid <= 1'b1;
		items_if.command <= it.command;
		items_if.sink_index <= it.sink_index;
		items_if.pos_x <= it.px;
		items_if.pos_y <= it.py;
		items_if.pos_z <= it.pz;
		items_if.body_mass <= it.mass;
		items_if.capture_radius <= it.radius;
		do @(posedge clk); while (!items_if.ready);
		sb.note_item(it);
		if ($urandom_range(99) < send_idle) begin
			items_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
	endtask

	task automatic drain();
		items_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input spg_pkg::reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= spg_pkg::CFG_AW'(4 * idx);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic configure(input logic [31:0] g, input logic [31:0] m,
			input logic [3:0] act);
		drain();
		write_reg(spg_pkg::REG_GRAV, g);
		write_reg(spg_pkg::REG_PMASS, m);
		write_reg(spg_pkg::REG_ACTIVE, {28'd0, act});
	endtask

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return center + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
			6, 7: return $urandom;
			8: return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return center;
		endcase
	endfunction

	function automatic item_t make_item(input logic [spg_pkg::CMD_W-1:0] cmd,
			input logic [2:0] idx,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
			input logic [31:0] mass, input logic [31:0] radius);
		item_t it;
		it.command = cmd; it.sink_index = idx;
		it.px = x; it.py = y; it.pz = z; it.mass = mass; it.radius = radius;
		return it;
	endfunction

	function automatic item_t rand_item();
		item_t it;
		int r;
		logic [spg_pkg::CMD_W-1:0] cmd;
		logic [31:0] radius;
		r = $urandom_range(99);
		cmd = (r < 25) ? spg_pkg::CMD_LOAD : (r < 65) ? spg_pkg::CMD_PART :
			(r < 95) ? spg_pkg::CMD_READ : CMD_UNUSED;
		case ($urandom_range(5))
			0: radius = 0;
			1: radius = $urandom;
			2: radius = 32'hFFFF_FFFF;
			default: radius = $urandom_range(0, 32'h0004_0000);
		endcase
		it = make_item(cmd, 3'($urandom_range(7)), rand_pos(), rand_pos(), rand_pos(),
			($urandom_range(1)) ? $urandom : $urandom_range(0, 32'h0004_0000), radius);
		return it;
	endfunction

	initial begin
		items_if.valid <= 1'b0;
		items_if.command <= spg_pkg::CMD_LOAD;
		items_if.sink_index <= '0;
		items_if.pos_x <= '0;
		items_if.pos_y <= '0;
		items_if.pos_z <= '0;
		items_if.body_mass <= '0;
		items_if.capture_radius <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		center = 32'h0001_0000;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no active sinks, unused command, read of a cleared accumulator
		send_item(make_item(spg_pkg::CMD_PART, 3'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0,
			32'h0));
		send_item(make_item(CMD_UNUSED, 3'd5, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5));
		send_item(make_item(spg_pkg::CMD_READ, 3'd7, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
		send_item(make_item(spg_pkg::CMD_LOAD, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
			32'h0));
		send_item(make_item(spg_pkg::CMD_LOAD, 3'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0));
		send_item(make_item(spg_pkg::CMD_LOAD, 3'd2, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'hFFFF_FFFF, 32'h0));
		send_item(make_item(spg_pkg::CMD_LOAD, 3'd3, 32'h0001_0000, 32'h0, 32'h0,
			32'h0002_0000, 32'h0001_0000));
		for (int i = 4; i < 8; i++)
			send_item(make_item(spg_pkg::CMD_LOAD, 3'(i), rand_pos(), rand_pos(), rand_pos(),
				$urandom, $urandom_range(0, 32'h0000_8000)));
		configure(32'h0001_0000, 32'h0001_0000, 4'd4);
		// coincident with a sink, extreme corners, inside a capture radius
		send_item(make_item(spg_pkg::CMD_PART, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
		send_item(make_item(spg_pkg::CMD_PART, 3'd0, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h0, 32'h0));
		send_item(make_item(spg_pkg::CMD_PART, 3'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h0, 32'h0));
		send_item(make_item(spg_pkg::CMD_PART, 3'd0, 32'h0000_8000, 32'h0, 32'h0, 32'h0,
			32'h0));
		send_item(make_item(spg_pkg::CMD_PART, 3'd0, 32'h0003_0000, 32'h0001_0000,
			32'hFFFF_0000, 32'h0, 32'h0));
		for (int i = 0; i < 4; i++)
			send_item(make_item(spg_pkg::CMD_READ, 3'(i), 32'h0, 32'h0, 32'h0, 32'h0,
				32'h0));

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: configure(spg_pkg::GRAV_RST, spg_pkg::PMASS_RST, 4'd1);
				1: configure($urandom, $urandom, 4'd3);
				2: configure(32'h0, 32'hFFFF_FFFF, 4'd8);
				3: configure(32'hFFFF_FFFF, 32'h0, 4'd15);
				4: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd2);
				default: configure($urandom_range(0, 32'h0004_0000),
					$urandom_range(0, 32'h0004_0000), 4'd0);
			endcase
			case (ph / 2)
				0: begin send_idle = 30; recv_idle = 60; end
				1: begin send_idle = 60; recv_idle = 30; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			center = (ph == 0) ? 32'h0001_0000 : $urandom;
			if (ph == 4) hold_cycles = 3000;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_item(rand_item());
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS sink_particle_gravity");
		end else begin
			$display("FAIL sink_particle_gravity");
		end
		$finish;
	end
endmodule
`default_nettype wire
